[design/plic_pkg.sv]
package plic_pkg;

   localparam int SRC_SLOTS        = 32;
   localparam int SRC_W            = 5;
   localparam int PRIO_W           = 3;
   localparam int OFFSET_W         = 26;
   localparam int DATA_W           = 32;

   localparam int DEF_NUM_SOURCES  = 32;
   localparam int PRIORITY_OFFSET  = 0;
   localparam int PENDING_OFFSET   = 4096;
   localparam int ENABLE_OFFSET    = 8192;
   localparam int THRESHOLD_OFFSET = 2097152;
   localparam int CLAIM_OFFSET     = 2097156;

   typedef enum logic [1:0] {
      FUNC_READ  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_RAISE = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [SRC_W-1:0]  idx;
   } cand_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic reduce;
      logic finalize;
      logic load_rsp;
   } cmd_type;

   // The right-hand candidate wins only with a strictly higher priority,
   // so ties keep the lower index.
   function automatic cand_type pick(input cand_type a, input cand_type b);
      cand_type r;
      if (b.prio > a.prio) begin
         r = b;
      end else begin
         r = a;
      end
      return r;
   endfunction

endpackage

[design/plic_if.sv]
interface plic_req_if
   import plic_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [1:0]          func;
   logic [OFFSET_W-1:0] offset;
   logic [DATA_W-1:0]   wdata;
   logic [SRC_W-1:0]    src;

   modport source (output valid, func, offset, wdata, src, input ready);
   modport sink (input valid, func, offset, wdata, src, output ready);
endinterface

interface plic_rsp_if
   import plic_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] rdata;
   logic              access_ok;
   logic              irq;

   modport source (output valid, rdata, access_ok, irq, input ready);
   modport sink (input valid, rdata, access_ok, irq, output ready);
endinterface

[design/platform_interrupt_controller_core.sv]
// A result is presented after its request passes through execute, two registered stages
// of the priority search tree, and the result load. The sequencer accepts a new request
// only once the previous one has been loaded into the result register.
// A result waiting in the output register stalls the sequencer only at the load step.
// Reset (synchronous, active high) clears priorities, masks, threshold and claim at once.
module platform_interrupt_controller_core
   import plic_pkg::*;
#(
   parameter int NUM_SOURCES = DEF_NUM_SOURCES
)
(
   input logic         clock,
   input logic         reset,
   plic_req_if.sink    req,
   plic_rsp_if.source  rsp
);

   cmd_type cmd;

   plic_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   plic_datapath #(
      .NUM_SOURCES (NUM_SOURCES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_func      (req.func),
      .req_offset    (req.offset),
      .req_wdata     (req.wdata),
      .req_source    (req.src),
      .rsp_rdata     (rsp.rdata),
      .rsp_access_ok (rsp.access_ok),
      .rsp_irq       (rsp.irq)
   );

endmodule

[design/plic_ctrl.sv]
module plic_ctrl
   import plic_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REDUCE,
      ST_FINAL,
      ST_RESPOND
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            state_in   = ST_FINAL;
         end
         ST_FINAL: begin
            cmd.finalize = 1'b1;
            state_in     = ST_RESPOND;
         end
         ST_RESPOND: begin
            // Wait here while the previous result still sits unclaimed.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[design/plic_datapath.sv]
module plic_datapath
   import plic_pkg::*;
#(
   parameter int NUM_SOURCES = DEF_NUM_SOURCES
)
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   input  logic [1:0]          req_func,
   input  logic [OFFSET_W-1:0] req_offset,
   input  logic [DATA_W-1:0]   req_wdata,
   input  logic [SRC_W-1:0]    req_source,
   output logic [DATA_W-1:0]   rsp_rdata,
   output logic                rsp_access_ok,
   output logic                rsp_irq
);

   localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
   localparam logic [NUM_SOURCES-1:0] SRC_MASK = ~(NUM_SOURCES'(1));
   localparam int GROUPS = 4;

   // Captured transaction
   logic [1:0]          func_ff;
   logic [OFFSET_W-1:0] offset_ff;
   logic [DATA_W-1:0]   wdata_ff;
   logic [SRC_W-1:0]    source_ff;

   // Architectural state
   logic [PRIO_W-1:0]      prio_ff [NUM_SOURCES];
   logic [NUM_SOURCES-1:0] pending_ff, pending_in;
   logic [NUM_SOURCES-1:0] enable_ff, enable_in;
   logic [PRIO_W-1:0]      thresh_ff, thresh_in;
   logic [SRC_W-1:0]       claimed_ff, claimed_in;
   logic                   prio_we;
   logic [IDX_W-1:0]       prio_waddr;

   // Step result and winner search
   logic [DATA_W-1:0] rdata_ff, rdata_in;
   logic              ok_ff, ok_in;
   cand_type          group_ff [GROUPS];
   cand_type          winner_ff;

   logic [DATA_W-1:0] rsp_rdata_ff;
   logic              rsp_ok_ff;
   logic              rsp_irq_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff   <= req_func;
         offset_ff <= req_offset;
         wdata_ff  <= req_wdata;
         source_ff <= req_source;
      end
   end

   logic             in_prio;
   logic [IDX_W-1:0] prio_idx;
   logic             src_valid;
   logic [IDX_W-1:0] src_idx;
   logic [IDX_W-1:0] win_idx;

   assign in_prio   = offset_ff < OFFSET_W'(PRIORITY_OFFSET + 4 * NUM_SOURCES);
   assign prio_idx  = offset_ff[IDX_W+1:2];
   assign src_valid = (source_ff != '0) && ({1'b0, source_ff} < (SRC_W+1)'(NUM_SOURCES));
   assign src_idx   = source_ff[IDX_W-1:0];
   assign win_idx   = winner_ff.idx[IDX_W-1:0];

   always_comb begin
      pending_in = pending_ff;
      enable_in  = enable_ff;
      thresh_in  = thresh_ff;
      claimed_in = claimed_ff;
      prio_we    = 1'b0;
      prio_waddr = prio_idx;
      rdata_in   = '0;
      ok_in      = 1'b0;
      unique case (func_type'(func_ff))
         FUNC_READ: begin
            ok_in = 1'b1;
            priority if (in_prio) begin
               rdata_in = DATA_W'(prio_ff[prio_idx]);
            end else if (offset_ff == OFFSET_W'(PENDING_OFFSET)) begin
               rdata_in = DATA_W'(pending_ff);
            end else if (offset_ff == OFFSET_W'(ENABLE_OFFSET)) begin
               rdata_in = DATA_W'(enable_ff);
            end else if (offset_ff == OFFSET_W'(THRESHOLD_OFFSET)) begin
               rdata_in = DATA_W'(thresh_ff);
            end else if (offset_ff == OFFSET_W'(CLAIM_OFFSET)) begin
               rdata_in = DATA_W'(winner_ff.idx);
               if (winner_ff.idx != '0) begin
                  pending_in[win_idx] = 1'b0;
                  claimed_in          = winner_ff.idx;
               end
            end else begin
               ok_in = 1'b0;
            end
         end
         FUNC_WRITE: begin
            ok_in    = 1'b1;
            rdata_in = wdata_ff;
            priority if (in_prio) begin
               prio_we = (prio_idx != '0);
            end else if (offset_ff == OFFSET_W'(PENDING_OFFSET)) begin
               // The pending mask is read only.
               ok_in = 1'b1;
            end else if (offset_ff == OFFSET_W'(ENABLE_OFFSET)) begin
               enable_in = wdata_ff[NUM_SOURCES-1:0] & SRC_MASK;
            end else if (offset_ff == OFFSET_W'(THRESHOLD_OFFSET)) begin
               thresh_in = wdata_ff[PRIO_W-1:0];
            end else if (offset_ff == OFFSET_W'(CLAIM_OFFSET)) begin
               if (wdata_ff != '0 && wdata_ff < DATA_W'(NUM_SOURCES) &&
                   wdata_ff[SRC_W-1:0] == claimed_ff) begin
                  claimed_in = '0;
               end
            end else begin
               ok_in    = 1'b0;
               rdata_in = '0;
            end
         end
         FUNC_RAISE: begin
            if (src_valid) begin
               pending_in[src_idx] = 1'b1;
            end
         end
         FUNC_CLEAR: begin
            if (src_valid) begin
               pending_in[src_idx] = 1'b0;
            end
         end
         default: ok_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SOURCES; i++) begin
            prio_ff[i] <= '0;
         end
         pending_ff <= '0;
         enable_ff  <= '0;
         thresh_ff  <= '0;
         claimed_ff <= '0;
      end else if (cmd.exec) begin
         if (prio_we) begin
            prio_ff[prio_waddr] <= wdata_ff[PRIO_W-1:0];
         end
         pending_ff <= pending_in;
         enable_ff  <= enable_in;
         thresh_ff  <= thresh_in;
         claimed_ff <= claimed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rdata_ff <= rdata_in;
         ok_ff    <= ok_in;
      end
   end

   // Candidates carry priority zero unless pending, enabled and above threshold.
   cand_type cand [SRC_SLOTS];
   for (genvar g = 0; g < SRC_SLOTS; g++) begin : g_cand
      if (g < NUM_SOURCES) begin : g_live
         assign cand[g].prio = (pending_ff[g] && enable_ff[g] && prio_ff[g] > thresh_ff)
                             ? prio_ff[g] : '0;
         assign cand[g].idx  = SRC_W'(g);
      end else begin : g_dead
         assign cand[g] = '0;
      end
   end

   cand_type lvl1 [16];
   cand_type lvl2 [8];
   cand_type lvl3 [GROUPS];
   cand_type lvl4 [2];
   cand_type lvl5;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         lvl1[i] = pick(cand[2*i], cand[2*i+1]);
      end
      for (int i = 0; i < 8; i++) begin
         lvl2[i] = pick(lvl1[2*i], lvl1[2*i+1]);
      end
      for (int i = 0; i < GROUPS; i++) begin
         lvl3[i] = pick(lvl2[2*i], lvl2[2*i+1]);
      end
   end

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         lvl4[i] = pick(group_ff[2*i], group_ff[2*i+1]);
      end
      lvl5 = pick(lvl4[0], lvl4[1]);
   end

   always_ff @(posedge clock) begin
      if (cmd.reduce) begin
         for (int i = 0; i < GROUPS; i++) begin
            group_ff[i] <= lvl3[i];
         end
      end
   end

   // The winner stays valid between transactions; the claim path relies on it.
   always_ff @(posedge clock) begin
      if (reset) begin
         winner_ff <= '0;
      end else if (cmd.finalize) begin
         winner_ff <= lvl5;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_rdata_ff <= rdata_ff;
         rsp_ok_ff    <= ok_ff;
         rsp_irq_ff   <= (winner_ff.idx != '0);
      end
   end

   assign rsp_rdata     = rsp_rdata_ff;
   assign rsp_access_ok = rsp_ok_ff;
   assign rsp_irq       = rsp_irq_ff;

endmodule

[tb/platform_interrupt_controller_core_checker.sv]
module platform_interrupt_controller_core_checker
   import plic_pkg::*;
(
   input  logic clock,
   input  logic reset,
   plic_req_if  req_mon,
   plic_rsp_if  rsp_mon,
   output int   fail_count,
   output int   expected_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SRC = DEF_NUM_SOURCES;
   localparam logic [63:0] SRC_SPAN = (64'd1 << NUM_SRC) - 64'd1;
   localparam logic [31:0] SRC_MASK = SRC_SPAN[31:0] & ~32'd1;
   localparam logic [31:0] PRIO_MASK = 32'h7;

   typedef struct packed {
      logic [DATA_W-1:0] rdata;
      logic              access_ok;
      logic              irq;
   } outcome_type;

   logic [PRIO_W-1:0] prio_tab [SRC_SLOTS];
   logic [31:0]       pend_bits;
   logic [31:0]       enab_bits;
   logic [PRIO_W-1:0] thresh;
   logic [SRC_W-1:0]  claimed;

   outcome_type awaited_rsp [$];
   int          errors = 0;

   initial begin
      fail_count = 0;
      expected_count = 0;
   end

   // Lowest-index source among those pending and enabled with the highest
   // priority strictly above the threshold; zero when none qualifies.
   function automatic logic [SRC_W-1:0] highest_ready_source();
      logic [SRC_W-1:0]  best;
      logic [PRIO_W-1:0] best_p;
      logic [31:0]       live;
      best = '0;
      best_p = '0;
      live = pend_bits & enab_bits & SRC_MASK;
      for (int i = 1; i < NUM_SRC; i++) begin
         if (live[i] && prio_tab[i] > thresh && prio_tab[i] > best_p) begin
            best = SRC_W'(i);
            best_p = prio_tab[i];
         end
      end
      return best;
   endfunction

   task automatic advance_controller(input func_type f, input logic [OFFSET_W-1:0] off,
                                     input logic [DATA_W-1:0] wdata,
                                     input logic [SRC_W-1:0] src, output outcome_type res);
      logic [OFFSET_W-1:0] rel;
      logic [SRC_W-1:0]    idx;
      logic [SRC_W-1:0]    win;
      logic                in_prio;
      res = '0;
      rel = off - OFFSET_W'(PRIORITY_OFFSET);
      idx = rel[SRC_W+1:2];
      in_prio = (off >= PRIORITY_OFFSET) && (off < PRIORITY_OFFSET + 4 * NUM_SRC);
      case (f)
         FUNC_READ: begin
            res.access_ok = 1'b1;
            if (in_prio) begin
               res.rdata = 32'(prio_tab[idx]);
            end else if (off == PENDING_OFFSET) begin
               res.rdata = pend_bits;
            end else if (off == ENABLE_OFFSET) begin
               res.rdata = enab_bits;
            end else if (off == THRESHOLD_OFFSET) begin
               res.rdata = 32'(thresh);
            end else if (off == CLAIM_OFFSET) begin
               win = highest_ready_source();
               if (win != 0) begin
                  pend_bits[win] = 1'b0;
                  claimed = win;
               end
               res.rdata = 32'(win);
            end else begin
               res.access_ok = 1'b0;
            end
         end
         FUNC_WRITE: begin
            res.access_ok = 1'b1;
            res.rdata = wdata;
            if (in_prio) begin
               if (idx != 0) begin
                  prio_tab[idx] = PRIO_W'(wdata & PRIO_MASK);
               end
            end else if (off == PENDING_OFFSET) begin
               // The pending mask is read only; the write is simply echoed.
            end else if (off == ENABLE_OFFSET) begin
               enab_bits = wdata & SRC_MASK;
            end else if (off == THRESHOLD_OFFSET) begin
               thresh = PRIO_W'(wdata & PRIO_MASK);
            end else if (off == CLAIM_OFFSET) begin
               if (wdata > 0 && wdata < NUM_SRC && wdata == 32'(claimed)) begin
                  claimed = '0;
               end
            end else begin
               res.access_ok = 1'b0;
               res.rdata = '0;
            end
         end
         FUNC_RAISE: begin
            if (src != 0 && src < NUM_SRC) begin
               pend_bits[src] = 1'b1;
            end
         end
         FUNC_CLEAR: begin
            if (src != 0 && src < NUM_SRC) begin
               pend_bits[src] = 1'b0;
            end
         end
         default: begin
         end
      endcase
      res.irq = (highest_ready_source() != 0);
   endtask

   task automatic report(input string field, input logic [DATA_W-1:0] want,
                         input logic [DATA_W-1:0] got);
      $display("%0t: %s differs, expected 0x%08h, observed 0x%08h", $realtime, field, want, got);
      errors++;
   endtask

   always @(posedge clock) begin
      outcome_type want;
      outcome_type fresh;
      if (reset) begin
         for (int i = 0; i < SRC_SLOTS; i++) begin
            prio_tab[i] = '0;
         end
         pend_bits = '0;
         enab_bits = '0;
         thresh = '0;
         claimed = '0;
         awaited_rsp.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_rsp.size() == 0) begin
               report("unexpected transaction rdata", '0, rsp_mon.rdata);
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_mon.rdata !== want.rdata) begin
                  report("rdata", want.rdata, rsp_mon.rdata);
               end
               if (rsp_mon.access_ok !== want.access_ok) begin
                  report("access_ok", 32'(want.access_ok), 32'(rsp_mon.access_ok));
               end
               if (rsp_mon.irq !== want.irq) begin
                  report("irq", 32'(want.irq), 32'(rsp_mon.irq));
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            advance_controller(func_type'(req_mon.func), req_mon.offset, req_mon.wdata,
                               req_mon.src, fresh);
            awaited_rsp.push_back(fresh);
         end
      end
      fail_count <= errors;
      expected_count <= awaited_rsp.size();
   end

endmodule

[tb/platform_interrupt_controller_core_test.sv]
module platform_interrupt_controller_core_test
   import plic_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1200;
   localparam int CYCLE_LIMIT = 250000;
   localparam int DRAIN_CYCLES = 12;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   expected_count;
   int   cycle_count = 0;
   logic calm = 1'b0;

   plic_req_if req_ch ();
   plic_rsp_if rsp_ch ();

   platform_interrupt_controller_core i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   platform_interrupt_controller_core_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .fail_count     (fail_count),
      .expected_count (expected_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("platform_interrupt_controller_core: mismatch");
         $finish;
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_READ;
      req_ch.offset = '0;
      req_ch.wdata = '0;
      req_ch.src = '0;
      rsp_ch.ready = 1'b0;
   end

   // During a calm stretch neither side inserts any idle cycles.
   function automatic int draw_pause();
      return calm ? 0 : $urandom_range(0, 9);
   endfunction

   // Mostly a handful of sources, so that raises, claims and completions meet.
   function automatic logic [SRC_W-1:0] hot_source();
      if ($urandom_range(0, 4) == 0) begin
         return SRC_W'($urandom_range(0, 31));
      end
      return ($urandom_range(0, 5) == 0) ? SRC_W'(31) : SRC_W'($urandom_range(1, 4));
   endfunction

   task automatic issue_request(input func_type f, input logic [OFFSET_W-1:0] off,
                                input logic [DATA_W-1:0] wdata, input logic [SRC_W-1:0] src);
      int gap;
      gap = draw_pause();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func <= f;
      req_ch.offset <= off;
      req_ch.wdata <= wdata;
      req_ch.src <= src;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic bus_read(input int off);
      issue_request(FUNC_READ, OFFSET_W'(off), $urandom, SRC_W'($urandom));
   endtask

   task automatic bus_write(input int off, input logic [DATA_W-1:0] wdata);
      issue_request(FUNC_WRITE, OFFSET_W'(off), wdata, SRC_W'($urandom));
   endtask

   task automatic source_event(input func_type f, input logic [SRC_W-1:0] src);
      issue_request(f, OFFSET_W'($urandom), $urandom, src);
   endtask

   // Before each transaction the result side may hold ready low for a random pause, except during a calm stretch.
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = draw_pause();
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge clock);
      end
   end

   initial begin
      int          kind;
      logic [SRC_W-1:0] src;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening: register extremes, ties, claim and completion corners.
      bus_write(PRIORITY_OFFSET, 32'hFFFF_FFFF);
      bus_read(PRIORITY_OFFSET);
      bus_write(PRIORITY_OFFSET + 4 * 31 + 3, 32'hFFFF_FFFF);
      bus_read(PRIORITY_OFFSET + 4 * 31);
      bus_write(PRIORITY_OFFSET + 4, 32'h0000_0007);
      bus_write(PRIORITY_OFFSET + 4 * 5 + 1, 32'hFFFF_FFF7);
      bus_write(ENABLE_OFFSET, 32'hFFFF_FFFF);
      bus_read(ENABLE_OFFSET);
      bus_read(CLAIM_OFFSET);
      source_event(FUNC_RAISE, 5'd0);
      source_event(FUNC_RAISE, 5'd31);
      source_event(FUNC_RAISE, 5'd5);
      source_event(FUNC_RAISE, 5'd1);
      bus_write(PENDING_OFFSET, 32'hFFFF_FFFF);
      bus_read(PENDING_OFFSET);
      bus_write(THRESHOLD_OFFSET, 32'hFFFF_FFFF);
      bus_read(THRESHOLD_OFFSET);
      bus_read(CLAIM_OFFSET);
      bus_write(THRESHOLD_OFFSET, 32'h0000_0000);
      bus_read(CLAIM_OFFSET);
      bus_read(CLAIM_OFFSET);
      bus_write(CLAIM_OFFSET, 32'h0000_0000);
      bus_write(CLAIM_OFFSET, 32'h0000_0005);
      source_event(FUNC_CLEAR, 5'd31);
      bus_read(CLAIM_OFFSET);
      bus_write(CLAIM_OFFSET, 32'hFFFF_FFFF);
      bus_read(26'h3FF_FFFF);
      bus_write(PRIORITY_OFFSET + 4 * 32, 32'hFFFF_FFFF);
      bus_read(CLAIM_OFFSET + 1);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            calm = ($urandom_range(0, 3) == 0);
         end
         kind = $urandom_range(0, 99);
         src = hot_source();
         if (kind < 14) begin
            source_event(FUNC_RAISE, src);
         end else if (kind < 20) begin
            source_event(FUNC_CLEAR, src);
         end else if (kind < 31) begin
            bus_write(PRIORITY_OFFSET + 4 * src + $urandom_range(0, 3), $urandom);
         end else if (kind < 36) begin
            bus_write(ENABLE_OFFSET, ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : $urandom);
         end else if (kind < 40) begin
            bus_write(THRESHOLD_OFFSET, ($urandom & ~32'h7) | $urandom_range(0, 3));
         end else if (kind < 60) begin
            bus_read(CLAIM_OFFSET);
         end else if (kind < 72) begin
            bus_write(CLAIM_OFFSET, ($urandom_range(0, 5) == 0) ? $urandom : 32'(src));
         end else if (kind < 84) begin
            case ($urandom_range(0, 3))
               0: bus_read(PRIORITY_OFFSET + $urandom_range(0, 4 * 32 - 1));
               1: bus_read(PENDING_OFFSET);
               2: bus_read(ENABLE_OFFSET);
               default: bus_read(THRESHOLD_OFFSET);
            endcase
         end else if (kind < 88) begin
            bus_write(PENDING_OFFSET, $urandom);
         end else if (kind < 95) begin
            issue_request(($urandom_range(0, 1) == 0) ? FUNC_READ : FUNC_WRITE,
                          OFFSET_W'($urandom), $urandom, SRC_W'($urandom));
         end else begin
            source_event(($urandom_range(0, 1) == 0) ? FUNC_RAISE : FUNC_CLEAR,
                         SRC_W'($urandom_range(0, 31)));
         end
      end
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (expected_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_count == 0) begin
         $display("platform_interrupt_controller_core: match");
      end else begin
         $display("platform_interrupt_controller_core: mismatch");
      end
      $finish;
   end

endmodule

[platform_interrupt_controller_core.f]
design/plic_pkg.sv
design/plic_if.sv
design/plic_ctrl.sv
design/plic_datapath.sv
design/platform_interrupt_controller_core.sv
tb/platform_interrupt_controller_core_checker.sv
tb/platform_interrupt_controller_core_test.sv
